FILE: hdl/fdr_pkg.sv
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared widths, fixed-point constants and types for the Fresnel
// reflectance pipeline.
// ----------------------------------------------------------------------------
package fdr_pkg;

	localparam int unsigned COS_W   = 16;	// |cos| in Q1.15, up to 1.0
	localparam int unsigned INDEX_W = 15;	// Q2.13 refractive index
	localparam int unsigned RAD_W   = 31;	// radicand, up to 2^30
	localparam int unsigned ROOT_W  = 16;	// root, up to 2^15
	localparam int unsigned PROD_W  = 30;	// index times cosine or sine
	localparam int unsigned DEN_W   = 31;	// sum of two products
	localparam int unsigned FRAC_W  = 30;	// fraction bits of a ratio

	localparam logic [15:0]  ONE_Q15    = 16'h8000;
	localparam logic [30:0]  ONE_Q30    = 31'h4000_0000;
	localparam logic [14:0]  INDEX_ONE  = 15'h2000;
	localparam logic [31:0]  ROUND_HALF = 32'h0000_8000;

	typedef logic [RAD_W-1:0]  rad_t;
	typedef logic [ROOT_W-1:0] root_t;

endpackage

FILE: hdl/fdr_sqrt_stage.sv
// ----------------------------------------------------------------------------
// fdr_sqrt_stage
// One registered step of a restoring floor square root: decides one root
// bit and keeps the remainder (radicand minus root squared).
// ----------------------------------------------------------------------------
module fdr_sqrt_stage
	import fdr_pkg::*;
#(
	parameter int unsigned BIT = 15,
	parameter int unsigned SW  = 1
) (
	input  logic          clk,
	input  logic          en,
	input  rad_t          rem_in,
	input  root_t         root_in,
	input  logic [SW-1:0] side_in,
	output rad_t          rem_s,
	output root_t         root_s,
	output logic [SW-1:0] side_s
);

	logic [31:0] delta;
	logic [31:0] diff;
	logic        take;
	rad_t        rem_nx;
	root_t       root_nx;

	// (root + 2^BIT)^2 - root^2 = root*2^(BIT+1) + 2^(2*BIT)
	always_comb begin
		delta   = ({16'd0, root_in} << (BIT + 1)) + (32'd1 << (2 * BIT));
		diff    = {1'b0, rem_in} - delta;
		take    = ({1'b0, rem_in} >= delta);
		rem_nx  = take ? diff[RAD_W-1:0] : rem_in;
		root_nx = take ? (root_in | (root_t'(1) << BIT)) : root_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s  <= rem_nx;
			root_s <= root_nx;
			side_s <= side_in;
		end
	end

endmodule

FILE: hdl/fdr_div_stage.sv
// ----------------------------------------------------------------------------
// fdr_div_stage
// One registered step of restoring long division. The quotient register
// also holds the dividend bits still to be brought down; each step shifts
// one out at the top and one quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module fdr_div_stage
	import fdr_pkg::*;
#(
	parameter int unsigned RW = 15,
	parameter int unsigned QW = 15,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] rem_in,
	input  logic [RW-1:0] divisor_in,
	input  logic [QW-1:0] quo_in,
	input  logic [SW-1:0] side_in,
	output logic [RW-1:0] rem_s,
	output logic [RW-1:0] divisor_s,
	output logic [QW-1:0] quo_s,
	output logic [SW-1:0] side_s
);

	logic [RW:0]   trial;
	logic [RW:0]   diff;
	logic          ge;
	logic [RW-1:0] rem_nx;

	// remainder stays below the divisor, so trial fits RW bits when not taken
	always_comb begin
		trial  = {rem_in, quo_in[QW-1]};
		diff   = trial - {1'b0, divisor_in};
		ge     = (trial >= {1'b0, divisor_in});
		rem_nx = ge ? diff[RW-1:0] : trial[RW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s     <= rem_nx;
			divisor_s <= divisor_in;
			quo_s     <= {quo_in[QW-2:0], ge};
			side_s    <= side_in;
		end
	end

endmodule

FILE: hdl/fresnel_dielectric_reflectance.sv
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarised Fresnel reflectance of a dielectric boundary, fixed point.
// ----------------------------------------------------------------------------
// Most of the pipeline depth comes from the bit-per-stage square roots and
// dividers.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// beat is stalled.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance
	import fdr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [16:0] cos_incident,
	input  logic [14:0]        index_incident,
	input  logic [14:0]        index_transmitted,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [15:0]        reflectance,
	output logic               total_internal
);

	localparam int unsigned NST  = 87;
	localparam int unsigned SW1  = COS_W + 2 * INDEX_W;
	localparam int unsigned SWD1 = COS_W + INDEX_W + 1;
	localparam int unsigned SW2  = COS_W + 2 * INDEX_W + 1;

	logic           en;
	logic [NST-1:0] valid_s;

	assign en         = !(valid_s[NST-1] && result_stall);
	assign item_stall = valid_s[NST-1] && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[NST-2:0], item_valid};
		end
	end

	// ---- s1: magnitude and clamps
	logic [16:0]        mag;
	logic [COS_W-1:0]   c_s1;
	logic [INDEX_W-1:0] ni_s1, nt_s1;

	assign mag = cos_incident[16] ? (17'd0 - cos_incident) : cos_incident;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= (mag > {1'b0, ONE_Q15}) ? ONE_Q15 : mag[15:0];
			ni_s1 <= (index_incident < INDEX_ONE) ? INDEX_ONE : index_incident;
			nt_s1 <= (index_transmitted < INDEX_ONE) ? INDEX_ONE : index_transmitted;
		end
	end

	// ---- s2: 1 - cos^2
	logic [31:0]        cc;
	rad_t               rad_s2;
	logic [COS_W-1:0]   c_s2;
	logic [INDEX_W-1:0] ni_s2, nt_s2;

	assign cc = c_s1 * c_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2 <= ONE_Q30 - cc[RAD_W-1:0];
			c_s2   <= c_s1;
			ni_s2  <= ni_s1;
			nt_s2  <= nt_s1;
		end
	end

	// ---- s3..s18: incident sine
	rad_t           sq1_rem  [0:ROOT_W];
	root_t          sq1_root [0:ROOT_W];
	logic [SW1-1:0] sq1_side [0:ROOT_W];

	assign sq1_rem[0]  = rad_s2;
	assign sq1_root[0] = '0;
	assign sq1_side[0] = {c_s2, ni_s2, nt_s2};

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt_si
		fdr_sqrt_stage #(.BIT(ROOT_W - 1 - k), .SW(SW1)) u_stage (
			.clk     (clk),
			.en      (en),
			.rem_in  (sq1_rem[k]),
			.root_in (sq1_root[k]),
			.side_in (sq1_side[k]),
			.rem_s   (sq1_rem[k+1]),
			.root_s  (sq1_root[k+1]),
			.side_s  (sq1_side[k+1])
		);
	end

	// ---- s19: ni * sin
	logic [30:0]        nisi;
	logic [PROD_W-1:0]  nisi_s19;
	logic [COS_W-1:0]   c_s19;
	logic [INDEX_W-1:0] ni_s19, nt_s19;

	assign nisi = {16'd0, sq1_side[ROOT_W][29:15]} * {15'd0, sq1_root[ROOT_W]};

	always_ff @(posedge clk) begin
		if (en) begin
			nisi_s19 <= nisi[PROD_W-1:0];
			c_s19    <= sq1_side[ROOT_W][45:30];
			ni_s19   <= sq1_side[ROOT_W][29:15];
			nt_s19   <= sq1_side[ROOT_W][14:0];
		end
	end

	// ---- s20: total internal reflection test, division set-up
	logic [INDEX_W-1:0] drem_s20, dquo_s20, nt_s20, ni_s20;
	logic [COS_W-1:0]   c_s20;
	logic               tir_s20;

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s20  <= (nisi_s19[29:15] >= nt_s19);
			drem_s20 <= nisi_s19[29:15];
			dquo_s20 <= nisi_s19[14:0];
			nt_s20   <= nt_s19;
			ni_s20   <= ni_s19;
			c_s20    <= c_s19;
		end
	end

	// ---- s21..s35: transmitted sine = ni*sin / nt
	logic [INDEX_W-1:0] d1_rem  [0:INDEX_W];
	logic [INDEX_W-1:0] d1_div  [0:INDEX_W];
	logic [INDEX_W-1:0] d1_quo  [0:INDEX_W];
	logic [SWD1-1:0]    d1_side [0:INDEX_W];

	assign d1_rem[0]  = drem_s20;
	assign d1_div[0]  = nt_s20;
	assign d1_quo[0]  = dquo_s20;
	assign d1_side[0] = {c_s20, ni_s20, tir_s20};

	for (genvar k = 0; k < INDEX_W; k++) begin : g_div_st
		fdr_div_stage #(.RW(INDEX_W), .QW(INDEX_W), .SW(SWD1)) u_stage (
			.clk        (clk),
			.en         (en),
			.rem_in     (d1_rem[k]),
			.divisor_in (d1_div[k]),
			.quo_in     (d1_quo[k]),
			.side_in    (d1_side[k]),
			.rem_s      (d1_rem[k+1]),
			.divisor_s  (d1_div[k+1]),
			.quo_s      (d1_quo[k+1]),
			.side_s     (d1_side[k+1])
		);
	end

	// ---- s36: 1 - st^2
	logic [29:0]    stst;
	rad_t           rad_s36;
	logic [SW2-1:0] side_s36;

	assign stst = d1_quo[INDEX_W] * d1_quo[INDEX_W];

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s36  <= ONE_Q30 - {1'b0, stst};
			side_s36 <= {d1_side[INDEX_W][31:16], d1_side[INDEX_W][15:1],
				d1_div[INDEX_W], d1_side[INDEX_W][0]};
		end
	end

	// ---- s37..s52: transmitted cosine
	rad_t           sq2_rem  [0:ROOT_W];
	root_t          sq2_root [0:ROOT_W];
	logic [SW2-1:0] sq2_side [0:ROOT_W];

	assign sq2_rem[0]  = rad_s36;
	assign sq2_root[0] = '0;
	assign sq2_side[0] = side_s36;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt_ct
		fdr_sqrt_stage #(.BIT(ROOT_W - 1 - k), .SW(SW2)) u_stage (
			.clk     (clk),
			.en      (en),
			.rem_in  (sq2_rem[k]),
			.root_in (sq2_root[k]),
			.side_in (sq2_side[k]),
			.rem_s   (sq2_rem[k+1]),
			.root_s  (sq2_root[k+1]),
			.side_s  (sq2_side[k+1])
		);
	end

	// ---- s53: the four index-cosine products
	logic [COS_W-1:0]   c2;
	logic [INDEX_W-1:0] ni2, nt2;
	root_t              ct2;
	logic [30:0]        mpa, mqa, mpb, mqb;
	logic [PROD_W-1:0]  pa_s53, qa_s53, pb_s53, qb_s53;
	logic               tir_s53;

	assign c2  = sq2_side[ROOT_W][46:31];
	assign ni2 = sq2_side[ROOT_W][30:16];
	assign nt2 = sq2_side[ROOT_W][15:1];
	assign ct2 = sq2_root[ROOT_W];
	assign mpa = {16'd0, nt2} * {15'd0, c2};
	assign mqa = {16'd0, ni2} * {15'd0, ct2};
	assign mpb = {16'd0, ni2} * {15'd0, c2};
	assign mqb = {16'd0, nt2} * {15'd0, ct2};

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s53  <= mpa[PROD_W-1:0];
			qa_s53  <= mqa[PROD_W-1:0];
			pb_s53  <= mpb[PROD_W-1:0];
			qb_s53  <= mqb[PROD_W-1:0];
			tir_s53 <= sq2_side[ROOT_W][0];
		end
	end

	// ---- s54: numerators and denominators
	logic [PROD_W-1:0] numa_s54, numb_s54;
	logic [DEN_W-1:0]  dena_s54, denb_s54;
	logic              tir_s54;

	always_ff @(posedge clk) begin
		if (en) begin
			numa_s54 <= (pa_s53 >= qa_s53) ? (pa_s53 - qa_s53) : (qa_s53 - pa_s53);
			numb_s54 <= (pb_s53 >= qb_s53) ? (pb_s53 - qb_s53) : (qb_s53 - pb_s53);
			dena_s54 <= {1'b0, pa_s53} + {1'b0, qa_s53};
			denb_s54 <= {1'b0, pb_s53} + {1'b0, qb_s53};
			tir_s54  <= tir_s53;
		end
	end

	// ---- s55: integer bit of each ratio (num <= den, so 0 or 1)
	logic             ia, ib;
	logic [DEN_W-1:0] na, nb;
	logic [DEN_W-1:0] rema_s55, remb_s55, dena_s55, denb_s55;
	logic             ia_s55, ib_s55, za_s55, zb_s55, tir_s55;

	assign na = {1'b0, numa_s54};
	assign nb = {1'b0, numb_s54};
	assign ia = (na >= dena_s54);
	assign ib = (nb >= denb_s54);

	always_ff @(posedge clk) begin
		if (en) begin
			rema_s55 <= ia ? (na - dena_s54) : na;
			remb_s55 <= ib ? (nb - denb_s54) : nb;
			dena_s55 <= dena_s54;
			denb_s55 <= denb_s54;
			ia_s55   <= ia;
			ib_s55   <= ib;
			za_s55   <= (dena_s54 == '0);
			zb_s55   <= (denb_s54 == '0);
			tir_s55  <= tir_s54;
		end
	end

	// ---- s56..s85: fraction bits of both ratios
	logic [DEN_W-1:0]  ra_rem  [0:FRAC_W];
	logic [DEN_W-1:0]  ra_div  [0:FRAC_W];
	logic [FRAC_W-1:0] ra_quo  [0:FRAC_W];
	logic [2:0]        ra_side [0:FRAC_W];
	logic [DEN_W-1:0]  rb_rem  [0:FRAC_W];
	logic [DEN_W-1:0]  rb_div  [0:FRAC_W];
	logic [FRAC_W-1:0] rb_quo  [0:FRAC_W];
	logic [1:0]        rb_side [0:FRAC_W];

	assign ra_rem[0]  = rema_s55;
	assign ra_div[0]  = dena_s55;
	assign ra_quo[0]  = '0;
	assign ra_side[0] = {ia_s55, za_s55, tir_s55};
	assign rb_rem[0]  = remb_s55;
	assign rb_div[0]  = denb_s55;
	assign rb_quo[0]  = '0;
	assign rb_side[0] = {ib_s55, zb_s55};

	for (genvar k = 0; k < FRAC_W; k++) begin : g_div_ratio
		fdr_div_stage #(.RW(DEN_W), .QW(FRAC_W), .SW(3)) u_par (
			.clk        (clk),
			.en         (en),
			.rem_in     (ra_rem[k]),
			.divisor_in (ra_div[k]),
			.quo_in     (ra_quo[k]),
			.side_in    (ra_side[k]),
			.rem_s      (ra_rem[k+1]),
			.divisor_s  (ra_div[k+1]),
			.quo_s      (ra_quo[k+1]),
			.side_s     (ra_side[k+1])
		);
		fdr_div_stage #(.RW(DEN_W), .QW(FRAC_W), .SW(2)) u_perp (
			.clk        (clk),
			.en         (en),
			.rem_in     (rb_rem[k]),
			.divisor_in (rb_div[k]),
			.quo_in     (rb_quo[k]),
			.side_in    (rb_side[k]),
			.rem_s      (rb_rem[k+1]),
			.divisor_s  (rb_div[k+1]),
			.quo_s      (rb_quo[k+1]),
			.side_s     (rb_side[k+1])
		);
	end

	// ---- s86: squares of the ratios; zero denominator counts as 1.0
	logic [30:0] ra, rb;
	logic [61:0] ra2, rb2;
	logic [30:0] sqa_s86, sqb_s86;
	logic        tir_s86;

	assign ra  = ra_side[FRAC_W][1] ? ONE_Q30 : {ra_side[FRAC_W][2], ra_quo[FRAC_W]};
	assign rb  = rb_side[FRAC_W][0] ? ONE_Q30 : {rb_side[FRAC_W][1], rb_quo[FRAC_W]};
	assign ra2 = {31'd0, ra} * {31'd0, ra};
	assign rb2 = {31'd0, rb} * {31'd0, rb};

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s86 <= ra2[60:30];
			sqb_s86 <= rb2[60:30];
			tir_s86 <= ra_side[FRAC_W][0];
		end
	end

	// ---- s87: half the sum, rounded, clamped; one on total internal reflection
	logic [31:0] sum;
	logic [15:0] refl_s87;
	logic        tir_s87;

	assign sum = {1'b0, sqa_s86} + {1'b0, sqb_s86} + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			if (tir_s86 || (sum[31:16] > ONE_Q15)) begin
				refl_s87 <= ONE_Q15;
			end else begin
				refl_s87 <= sum[31:16];
			end
			tir_s87 <= tir_s86;
		end
	end

	assign result_valid   = valid_s[NST-1];
	assign reflectance    = refl_s87;
	assign total_internal = tir_s87;

	// ---- checks
	a_tir_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && total_internal |-> reflectance == ONE_Q15)
		else $error("total internal reflection without full reflectance");

	a_refl_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> reflectance <= ONE_Q15)
		else $error("reflectance above one");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a stalled result beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("stalled result beat dropped");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives incidence cosines and index pairs into the Fresnel reflectance
// pipeline and checks every result beat against a typed-in result or a fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fdr_pkg::*;

	localparam int LATENCY = 87;
	localparam int N_RANDOM = 1630;

	typedef struct packed {
		logic signed [16:0] cosv;
		logic [14:0]        ni;
		logic [14:0]        nt;
	} beat_in_t;

	typedef struct packed {
		logic [15:0] refl;
		logic        tir;
	} beat_out_t;

	// directed row: stimulus, whether a typed-in result applies, that result
	typedef struct packed {
		beat_in_t  stim;
		logic      typed;
		beat_out_t res;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic signed [16:0] cos_incident = '0;
	logic [14:0]        index_incident = INDEX_ONE;
	logic [14:0]        index_transmitted = INDEX_ONE;
	logic               result_valid;
	logic               result_stall = 1'b1;
	logic [15:0]        reflectance;
	logic               total_internal;

	beat_out_t reflect_due[$];
	int        fails = 0;
	bit        feeding_done = 1'b0;
	bit        hold_off = 1'b0;

	fresnel_dielectric_reflectance dut (.*);

	always #5 clk = ~clk;

	function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] amp_sq(input logic [63:0] p, input logic [63:0] q);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] r;
		num = (p >= q) ? p - q : q - p;
		den = p + q;
		r = (den == 0) ? 64'(ONE_Q30) : (num << 30) / den;
		return (r * r) >> 30;
	endfunction

	function automatic beat_out_t fresnel_predict(input beat_in_t b);
		logic [63:0] c, ni, nt, si, st, ct, sum;
		beat_out_t o;
		c = b.cosv[16] ? 64'(-b.cosv) & 64'h1FFFF : 64'(b.cosv) & 64'h1FFFF;
		if (b.cosv == -17'sd65536) c = 65536;
		if (c > 32768) c = 32768;
		ni = (b.ni < INDEX_ONE) ? 64'(INDEX_ONE) : 64'(b.ni);
		nt = (b.nt < INDEX_ONE) ? 64'(INDEX_ONE) : 64'(b.nt);
		si = sqrt_floor(64'(ONE_Q30) - c * c);
		if (ni * si >= 32768 * nt) begin
			o.refl = ONE_Q15;
			o.tir = 1'b1;
			return o;
		end
		st = (ni * si) / nt;
		ct = sqrt_floor(64'(ONE_Q30) - st * st);
		sum = (amp_sq(nt * c, ni * ct) + amp_sq(ni * c, nt * ct) + 32768) >> 16;
		if (sum > 32768) sum = 32768;
		o.refl = sum[15:0];
		o.tir = 1'b0;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	function automatic beat_in_t random_beat();
		beat_in_t b;
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) b.cosv = 17'($urandom);	// full raw range, saturation too
		else if (k == 1) b.cosv = $urandom_range(0, 1) ? 17'sd32768 : -17'sd32768;
		else b.cosv = 17'($signed($urandom_range(0, 65536)) - 32768);
		k = $urandom_range(0, 9);
		b.ni = (k == 0) ? 15'($urandom) : 15'($urandom_range(8192, 32767));
		k = $urandom_range(0, 9);
		b.nt = (k == 0) ? 15'($urandom) : 15'($urandom_range(8192, 32767));
		return b;
	endfunction

	task automatic send_beat(input beat_in_t b, input logic typed, input beat_out_t res);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ?
			(($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cos_incident <= b.cosv;
		index_incident <= b.ni;
		index_transmitted <= b.nt;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		reflect_due.push_back(typed ? res : fresnel_predict(b));
	endtask

	initial begin
		row_t rows[$];
		beat_out_t none;
		none = '0;
		rows = '{
			'{'{17'sd32768, 15'd8192, 15'd8192}, 1'b1, '{16'd0, 1'b0}},
			'{'{17'sd0, 15'd8192, 15'd8192}, 1'b1, '{16'd32768, 1'b1}},
			'{'{17'sd0, 15'd16384, 15'd8192}, 1'b1, '{16'd32768, 1'b1}},
			'{'{-17'sd32768, 15'd32767, 15'd32767}, 1'b1, '{16'd0, 1'b0}},
			'{'{17'sd65535, 15'd8192, 15'd8192}, 1'b1, '{16'd0, 1'b0}},
			'{'{-17'sd65536, 15'd8192, 15'd8192}, 1'b1, '{16'd0, 1'b0}},
			'{'{17'sd40000, 15'd0, 15'd0}, 1'b1, '{16'd0, 1'b0}},
			'{'{17'sd32768, 15'd8192, 15'd32767}, 1'b0, none},
			'{'{17'sd32768, 15'd32767, 15'd8192}, 1'b0, none},
			'{'{-17'sd1, 15'd8192, 15'd32767}, 1'b0, none},
			'{'{17'sd1, 15'd32767, 15'd8192}, 1'b1, '{16'd32768, 1'b1}},
			'{'{17'sd23170, 15'd12288, 15'd8192}, 1'b0, none},
			'{'{17'sd23170, 15'd8192, 15'd12288}, 1'b0, none},
			'{'{-17'sd16384, 15'd10923, 15'd8192}, 1'b0, none},
			'{'{17'sd28378, 15'd12288, 15'd8192}, 1'b0, none},
			'{'{17'sd100, 15'd4000, 15'd8000}, 1'b0, none},
			'{'{17'sd30000, 15'd21000, 15'd8191}, 1'b0, none},
			'{'{-17'sd12345, 15'd32767, 15'd32766}, 1'b0, none},
			'{'{17'sd16384, 15'd8192, 15'd16384}, 1'b0, none},
			'{'{17'sd32767, 15'd16384, 15'd16383}, 1'b0, none}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_beat(rows[i].stim, rows[i].typed, rows[i].res);
		for (int i = 0; i < N_RANDOM; i++) begin
			// long receiver hold-off while the sender keeps offering
			if (i == 400) hold_off = 1'b1;
			send_beat(random_beat(), 1'b0, none);
		end
		item_valid <= 1'b0;
		feeding_done = 1'b1;
	end

	// receiver stall pattern, with one long hold-off counted in cycles
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end
			n = ($urandom_range(0, 3) == 0) ?
				(($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		beat_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (reflect_due.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				fails++;
			end else begin
				want = reflect_due.pop_front();
				if (reflectance !== want.refl) report_mismatch("reflectance", reflectance, want.refl);
				if (total_internal !== want.tir)
					report_mismatch("total_internal", total_internal, want.tir);
			end
		end
	end

	initial begin
		wait (feeding_done);
		while (reflect_due.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (fails == 0 && reflect_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#3ms;
		$display("status: fail");
		$finish;
	end

endmodule
